>>> hdl/complex_arith_unit_macros.svh
// Assertion macros for the complex arithmetic unit.
`ifndef COMPLEX_ARITH_UNIT_MACROS_SVH
`define COMPLEX_ARITH_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// The consequent must hold in the same cycle as the antecedent.
`define CAU_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// The consequent must hold in the cycle after the antecedent.
`define CAU_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define CAU_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define CAU_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

>>> hdl/cau_pkg.sv
// Types, constants and the saturation function of the complex arithmetic unit.
package cau_pkg;
   localparam int DW       = 32;
   localparam int DivSteps = DW + 1;
   localparam logic [2*DW:0] Lim = (2*DW+1)'(1) << (DW - 1);

   typedef enum logic [1:0] {ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV} action_type;

   typedef struct packed {
      action_type           action;
      logic signed [DW-1:0] a_re;
      logic signed [DW-1:0] a_im;
      logic signed [DW-1:0] b_re;
      logic signed [DW-1:0] b_im;
   } req_type;

   typedef struct packed {
      logic signed [DW-1:0] res_re;
      logic signed [DW-1:0] res_im;
      logic                 overflow;
      logic                 div_zero;
   } rsp_type;

   // Combined sums and divisor leaving the multiplier front end.
   typedef struct packed {
      action_type             action;
      logic signed [2*DW:0]   re_s;
      logic signed [2*DW:0]   im_s;
      logic [2*DW-1:0]        den;
      logic signed [DW:0]     as_re;
      logic signed [DW:0]     as_im;
   } front_type;

   // Long division state, both parts share the divisor.
   typedef struct packed {
      logic [2*DW-1:0] rem_re;
      logic [2*DW-1:0] rem_im;
      logic [DW:0]     num_re;
      logic [DW:0]     num_im;
      logic [DW:0]     q_re;
      logic [DW:0]     q_im;
      logic [2*DW-1:0] den;
   } dv_type;

   // Control and finished results carried alongside the divider.
   typedef struct packed {
      logic    is_div;
      logic    div_zero;
      logic    neg_re;
      logic    neg_im;
      logic    big_re;
      logic    big_im;
      rsp_type res;
   } side_type;

   typedef struct packed {
      logic                 ovf;
      logic signed [DW-1:0] val;
   } sat_type;

   // Applies the sign to a magnitude and clamps it to the output range.
   function automatic sat_type saturate(input logic neg, input logic [2*DW:0] mag);
      sat_type r;
      r.ovf = 1'b0;
      if (neg) begin
         if (mag > Lim) begin
            r.ovf = 1'b1;
            r.val = {1'b1, {(DW-1){1'b0}}};
         end else begin
            r.val = -$signed(mag[DW-1:0]);
         end
      end else begin
         if (mag >= Lim) begin
            r.ovf = 1'b1;
            r.val = {1'b0, {(DW-1){1'b1}}};
         end else begin
            r.val = $signed(mag[DW-1:0]);
         end
      end
      return r;
   endfunction
endpackage

>>> hdl/complex_arith_unit.sv
// Complex add, subtract, multiply and divide on signed fixed point.
// Pipeline: two multiply stages, two set-up stages, 33 long-division steps and one output
// stage, the same for every operation. Throughput: one item per cycle while no result waits
// for transfer; the divider has one registered step per quotient bit.
// The whole pipeline holds while a result waits for transfer.
// Synchronous active-high reset clears the valid bits only; data registers are not reset.
`include "complex_arith_unit_macros.svh"
module complex_arith_unit import cau_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp
);
   logic      en;
   logic      fr_valid;
   front_type fr_item;
   logic      st_valid [DivSteps+1];
   side_type  st_side  [DivSteps+1];
   dv_type    st_dv    [DivSteps+1];

   // The pipeline advances whenever the output register is free or emptying.
   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;

   cau_front u_front (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(req_valid), .in_item(req),
      .out_valid(fr_valid), .out_item(fr_item)
   );

   cau_prep #(.FRAC_BITS(FRAC_BITS)) u_prep (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(fr_valid), .in_item(fr_item),
      .out_valid(st_valid[0]), .out_side(st_side[0]), .out_dv(st_dv[0])
   );

   // Chain of long-division steps, one quotient bit each.
   for (genvar i = 0; i < DivSteps; i++) begin : g_div
      cau_div_step u_step (
         .clock(clock), .reset(reset), .en(en),
         .in_valid(st_valid[i]), .in_side(st_side[i]), .in_dv(st_dv[i]),
         .out_valid(st_valid[i+1]), .out_side(st_side[i+1]), .out_dv(st_dv[i+1])
      );
   end

   cau_back u_back (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(st_valid[DivSteps]), .in_side(st_side[DivSteps]),
      .in_dv(st_dv[DivSteps]),
      .out_valid(rsp_valid), .out_item(rsp)
   );

   // A zero divisor never reports saturation and always gives a zero result.
   `CAU_ASSERT_IMPLY(a_dz_no_ovf, clock, reset, rsp_valid && rsp.div_zero, !rsp.overflow)
   `CAU_ASSERT_IMPLY(a_dz_zero, clock, reset, rsp_valid && rsp.div_zero, rsp.res_re == 0 && rsp.res_im == 0)
   // No result is presented in the cycle after reset.
   `CAU_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid && !st_valid[0])
endmodule

>>> hdl/cau_front.sv
// Multiplier front end: partial products, then combined sums and divisor.
module cau_front import cau_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      en,
   input  logic      in_valid,
   input  req_type   in_item,
   output logic      out_valid,
   output front_type out_item
);
   logic                   s1_valid_ff;
   action_type             s1_act_ff;
   logic signed [2*DW-1:0] p_rr_ff, p_ii_ff, p_ir_ff, p_ri_ff, b_rr_ff, b_ii_ff;
   logic signed [2*DW-1:0] p_rr_in, p_ii_in, p_ir_in, p_ri_in, b_rr_in, b_ii_in;
   logic signed [DW:0]     as_re_ff, as_im_ff, as_re_in, as_im_in;
   logic                   s2_valid_ff;
   front_type              s2_ff, s2_in;

   // First stage: six products and the add or subtract result.
   always_comb begin
      p_rr_in = (2*DW)'(in_item.a_re) * (2*DW)'(in_item.b_re);
      p_ii_in = (2*DW)'(in_item.a_im) * (2*DW)'(in_item.b_im);
      p_ir_in = (2*DW)'(in_item.a_im) * (2*DW)'(in_item.b_re);
      p_ri_in = (2*DW)'(in_item.a_re) * (2*DW)'(in_item.b_im);
      b_rr_in = (2*DW)'(in_item.b_re) * (2*DW)'(in_item.b_re);
      b_ii_in = (2*DW)'(in_item.b_im) * (2*DW)'(in_item.b_im);
      if (in_item.action == ACT_SUB) begin
         as_re_in = (DW+1)'(in_item.a_re) - (DW+1)'(in_item.b_re);
         as_im_in = (DW+1)'(in_item.a_im) - (DW+1)'(in_item.b_im);
      end else begin
         as_re_in = (DW+1)'(in_item.a_re) + (DW+1)'(in_item.b_re);
         as_im_in = (DW+1)'(in_item.a_im) + (DW+1)'(in_item.b_im);
      end
   end

   // Second stage: product sums for multiply or divide, and the divisor.
   always_comb begin
      s2_in.action = s1_act_ff;
      s2_in.as_re  = as_re_ff;
      s2_in.as_im  = as_im_ff;
      s2_in.den    = $unsigned(b_rr_ff) + $unsigned(b_ii_ff);
      if (s1_act_ff == ACT_DIV) begin
         s2_in.re_s = (2*DW+1)'(p_rr_ff) + (2*DW+1)'(p_ii_ff);
         s2_in.im_s = (2*DW+1)'(p_ir_ff) - (2*DW+1)'(p_ri_ff);
      end else begin
         s2_in.re_s = (2*DW+1)'(p_rr_ff) - (2*DW+1)'(p_ii_ff);
         s2_in.im_s = (2*DW+1)'(p_ir_ff) + (2*DW+1)'(p_ri_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_act_ff <= in_item.action;
         p_rr_ff   <= p_rr_in;
         p_ii_ff   <= p_ii_in;
         p_ir_ff   <= p_ir_in;
         p_ri_ff   <= p_ri_in;
         b_rr_ff   <= b_rr_in;
         b_ii_ff   <= b_ii_in;
         as_re_ff  <= as_re_in;
         as_im_ff  <= as_im_in;
         s2_ff     <= s2_in;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_item  = s2_ff;
endmodule

>>> hdl/cau_prep.sv
// Magnitudes, rounding and saturation of non-divide results, divider set-up.
module cau_prep import cau_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      en,
   input  logic      in_valid,
   input  front_type in_item,
   output logic      out_valid,
   output side_type  out_side,
   output dv_type    out_dv
);
   localparam int NW  = 2*DW + FRAC_BITS + 1;
   localparam int HiW = NW - DW - 1;
   localparam logic [2*DW:0] Half = ((2*DW+1)'(1) << FRAC_BITS) >> 1;

   logic               s3_valid_ff;
   action_type         s3_act_ff;
   logic               neg_re_ff, neg_im_ff, neg_re_in, neg_im_in;
   logic [2*DW-1:0]    mag_re_ff, mag_im_ff, mag_re_in, mag_im_in;
   logic [2*DW-1:0]    den_ff;
   logic signed [DW:0] as_re_ff, as_im_ff;
   logic               s4_valid_ff;
   side_type           side_ff, side_in;
   dv_type             dv_ff, dv_in;

   logic [NW-1:0]   num_re, num_im;
   logic [HiW-1:0]  hi_re, hi_im;
   logic [2*DW:0]   rnd_re, rnd_im;
   logic [DW:0]     asm_re, asm_im;
   logic            asn_re, asn_im;
   sat_type         sat_re, sat_im;

   // Third stage: sign and magnitude of both sums.
   always_comb begin
      neg_re_in = in_item.re_s[2*DW];
      neg_im_in = in_item.im_s[2*DW];
      mag_re_in = neg_re_in ? (2*DW)'(-in_item.re_s) : (2*DW)'(in_item.re_s);
      mag_im_in = neg_im_in ? (2*DW)'(-in_item.im_s) : (2*DW)'(in_item.im_s);
   end

   // Fourth stage: finish add, subtract and multiply; load the divider.
   always_comb begin
      asn_re = as_re_ff[DW];
      asn_im = as_im_ff[DW];
      asm_re = asn_re ? $unsigned(-as_re_ff) : $unsigned(as_re_ff);
      asm_im = asn_im ? $unsigned(-as_im_ff) : $unsigned(as_im_ff);
      rnd_re = ({1'b0, mag_re_ff} + Half) >> FRAC_BITS;
      rnd_im = ({1'b0, mag_im_ff} + Half) >> FRAC_BITS;
      if (s3_act_ff == ACT_MUL) begin
         sat_re = saturate(neg_re_ff, rnd_re);
         sat_im = saturate(neg_im_ff, rnd_im);
      end else begin
         sat_re = saturate(asn_re, (2*DW+1)'(asm_re));
         sat_im = saturate(asn_im, (2*DW+1)'(asm_im));
      end

      // The numerator carries one extra fractional bit for rounding.
      num_re = {mag_re_ff, (FRAC_BITS+1)'(0)};
      num_im = {mag_im_ff, (FRAC_BITS+1)'(0)};
      hi_re  = num_re[NW-1:DW+1];
      hi_im  = num_im[NW-1:DW+1];

      side_in.is_div       = (s3_act_ff == ACT_DIV);
      side_in.div_zero     = (den_ff == '0);
      side_in.neg_re       = neg_re_ff;
      side_in.neg_im       = neg_im_ff;
      side_in.big_re       = ((2*DW)'(hi_re) >= den_ff);
      side_in.big_im       = ((2*DW)'(hi_im) >= den_ff);
      side_in.res.res_re   = sat_re.val;
      side_in.res.res_im   = sat_im.val;
      side_in.res.overflow = sat_re.ovf | sat_im.ovf;
      side_in.res.div_zero = 1'b0;

      dv_in.rem_re = (2*DW)'(hi_re);
      dv_in.rem_im = (2*DW)'(hi_im);
      dv_in.num_re = num_re[DW:0];
      dv_in.num_im = num_im[DW:0];
      dv_in.q_re   = '0;
      dv_in.q_im   = '0;
      dv_in.den    = den_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else if (en) begin
         s3_valid_ff <= in_valid;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s3_act_ff <= in_item.action;
         neg_re_ff <= neg_re_in;
         neg_im_ff <= neg_im_in;
         mag_re_ff <= mag_re_in;
         mag_im_ff <= mag_im_in;
         den_ff    <= in_item.den;
         as_re_ff  <= in_item.as_re;
         as_im_ff  <= in_item.as_im;
         side_ff   <= side_in;
         dv_ff     <= dv_in;
      end
   end

   assign out_valid = s4_valid_ff;
   assign out_side  = side_ff;
   assign out_dv    = dv_ff;
endmodule

>>> hdl/cau_div_step.sv
// One restoring long-division step for both result parts.
module cau_div_step import cau_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     en,
   input  logic     in_valid,
   input  side_type in_side,
   input  dv_type   in_dv,
   output logic     out_valid,
   output side_type out_side,
   output dv_type   out_dv
);
   logic     valid_ff;
   side_type side_ff;
   dv_type   dv_ff, dv_in;
   logic [2*DW:0] tr_re, tr_im;

   // Bring down the next numerator bit and subtract where the divisor fits.
   always_comb begin
      tr_re = {in_dv.rem_re, in_dv.num_re[DW]};
      tr_im = {in_dv.rem_im, in_dv.num_im[DW]};
      dv_in = in_dv;
      dv_in.num_re = {in_dv.num_re[DW-1:0], 1'b0};
      dv_in.num_im = {in_dv.num_im[DW-1:0], 1'b0};
      if (tr_re >= {1'b0, in_dv.den}) begin
         dv_in.rem_re = (2*DW)'(tr_re - {1'b0, in_dv.den});
         dv_in.q_re   = {in_dv.q_re[DW-1:0], 1'b1};
      end else begin
         dv_in.rem_re = tr_re[2*DW-1:0];
         dv_in.q_re   = {in_dv.q_re[DW-1:0], 1'b0};
      end
      if (tr_im >= {1'b0, in_dv.den}) begin
         dv_in.rem_im = (2*DW)'(tr_im - {1'b0, in_dv.den});
         dv_in.q_im   = {in_dv.q_im[DW-1:0], 1'b1};
      end else begin
         dv_in.rem_im = tr_im[2*DW-1:0];
         dv_in.q_im   = {in_dv.q_im[DW-1:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff <= in_side;
         dv_ff   <= dv_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_side  = side_ff;
   assign out_dv    = dv_ff;
endmodule

>>> hdl/cau_back.sv
// Final rounding of the quotients and the output register.
module cau_back import cau_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     en,
   input  logic     in_valid,
   input  side_type in_side,
   input  dv_type   in_dv,
   output logic     out_valid,
   output rsp_type  out_item
);
   logic        valid_ff;
   rsp_type     rsp_ff, rsp_in;
   logic [DW:0] rq_re, rq_im;
   sat_type     sat_re, sat_im;

   // The quotient holds one extra bit; round half away from zero, then clamp.
   // The increment is one bit wider so that an all-ones quotient cannot wrap.
   always_comb begin
      rq_re  = (DW+1)'(({1'b0, in_dv.q_re} + (DW+2)'(1)) >> 1);
      rq_im  = (DW+1)'(({1'b0, in_dv.q_im} + (DW+2)'(1)) >> 1);
      sat_re = saturate(in_side.neg_re,
                        in_side.big_re ? {(2*DW+1){1'b1}} : (2*DW+1)'(rq_re));
      sat_im = saturate(in_side.neg_im,
                        in_side.big_im ? {(2*DW+1){1'b1}} : (2*DW+1)'(rq_im));
      if (!in_side.is_div) begin
         rsp_in = in_side.res;
      end else if (in_side.div_zero) begin
         rsp_in = '0;
         rsp_in.div_zero = 1'b1;
      end else begin
         rsp_in.res_re   = sat_re.val;
         rsp_in.res_im   = sat_im.val;
         rsp_in.overflow = sat_re.ovf | sat_im.ovf;
         rsp_in.div_zero = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_ff <= rsp_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = rsp_ff;
endmodule

>>> tb/complex_arith_unit_tb.sv
// Self-checking testbench for the complex arithmetic unit: table-driven directed items, then random traffic.
`timescale 1ns / 100ps
module complex_arith_unit_tb;
   import cau_pkg::*;

   localparam logic signed [DW-1:0] MaxVal = {1'b0, {(DW-1){1'b1}}};
   localparam logic signed [DW-1:0] MinVal = {1'b1, {(DW-1){1'b0}}};
   localparam logic signed [DW-1:0] One    = 32'sh0001_0000;
   localparam int RandItems = 1850;

   typedef struct {
      req_type r;
      logic    typed;
      rsp_type want;
   } stim_row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp;

   rsp_type pending_q[$];
   int      errors = 0;
   int      checked = 0;
   int      snd_idle = 0;
   int      rcv_idle = 0;
   int      n_div_zero = 0;
   int      n_ovf = 0;

   complex_arith_unit u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req(req),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
   );

   // Clock, 10 ns period.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Signs a magnitude and clamps it to the output range, flagging any clamp.
   function automatic logic signed [DW-1:0] clamp_part(input logic neg, input logic [127:0] mag,
                                                       inout logic ovf);
      logic [127:0] lim;
      lim = 128'd1 << (DW - 1);
      if (neg && mag > lim) begin
         ovf = 1'b1;
         return MinVal;
      end
      if (!neg && mag >= lim) begin
         ovf = 1'b1;
         return MaxVal;
      end
      return neg ? -$signed(mag[DW-1:0]) : $signed(mag[DW-1:0]);
   endfunction

   // Exact complex arithmetic with one final rounding, ties away from zero.
   function automatic rsp_type complex_result(input req_type r);
      logic signed [127:0] ar, ai, br, bi, sre, sim;
      logic [127:0]        mre, mim, den, q, rem;
      logic                nre, nim, ovf;
      rsp_type             o;
      ar = r.a_re; ai = r.a_im; br = r.b_re; bi = r.b_im;
      ovf = 1'b0;
      o = '0;
      case (r.action)
         ACT_ADD: begin
            sre = ar + br; sim = ai + bi;
         end
         ACT_SUB: begin
            sre = ar - br; sim = ai - bi;
         end
         ACT_MUL: begin
            sre = ar * br - ai * bi; sim = ai * br + ar * bi;
         end
         default: begin
            sre = ar * br + ai * bi; sim = ai * br - ar * bi;
         end
      endcase
      nre = sre < 0; nim = sim < 0;
      mre = nre ? -sre : sre;
      mim = nim ? -sim : sim;
      if (r.action == ACT_MUL) begin
         mre = (mre + (128'd1 << 15)) >> 16;
         mim = (mim + (128'd1 << 15)) >> 16;
      end else if (r.action == ACT_DIV) begin
         den = br * br + bi * bi;
         if (den == 0) begin
            o.div_zero = 1'b1;
            return o;
         end
         q = (mre << 16) / den; rem = (mre << 16) % den;
         if ((rem << 1) >= den) q = q + 1;
         mre = q;
         q = (mim << 16) / den; rem = (mim << 16) % den;
         if ((rem << 1) >= den) q = q + 1;
         mim = q;
      end
      if (mre == 0) nre = 1'b0;
      if (mim == 0) nim = 1'b0;
      o.res_re = clamp_part(nre, mre, ovf);
      o.res_im = clamp_part(nim, mim, ovf);
      o.overflow = ovf;
      return o;
   endfunction

   function automatic stim_row_type row(input action_type act, input logic signed [DW-1:0] a_re,
                                        a_im, b_re, b_im);
      stim_row_type s;
      s.r = '{act, a_re, a_im, b_re, b_im};
      s.typed = 1'b0;
      s.want = '0;
      return s;
   endfunction

   function automatic stim_row_type row_exp(input stim_row_type s, input rsp_type w);
      s.typed = 1'b1;
      s.want = w;
      return s;
   endfunction

   // Operand values biased towards small numbers, zero and extremes.
   function automatic logic signed [DW-1:0] rand_operand();
      case ($urandom_range(9))
         0:       return MaxVal - $urandom_range(2);
         1:       return MinVal + $urandom_range(2);
         2:       return 0;
         3, 4:    return $signed($urandom_range(16'hffff) << $urandom_range(8, 24))
                         * ($urandom_range(1) ? 1 : -1);
         5:       return $signed($urandom_range(512)) - 256;
         default: return $signed($urandom());
      endcase
   endfunction

   // Holds one item on the request channel until it transfers.
   task automatic send_item(input req_type r, input rsp_type want);
      logic ready_s;
      while ($urandom_range(99) < snd_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req <= r;
      do begin
         @(negedge clock);
         ready_s = req_ready;
         if (ready_s) pending_q.push_back(want);
         @(posedge clock);
      end while (!ready_s);
   endtask

   // Result side stalls at random.
   always @(posedge clock) begin
      rsp_ready <= !reset && ($urandom_range(99) >= rcv_idle);
   end

   // Compare each result transfer with the oldest expectation.
   always @(negedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_q.size() == 0) begin
            $display("%0t: unexpected result %h", $time, rsp);
            errors++;
         end else begin
            rsp_type w;
            w = pending_q.pop_front();
            checked++;
            if (rsp.div_zero) n_div_zero++;
            if (rsp.overflow) n_ovf++;
            if (rsp.res_re !== w.res_re)
               $display("%0t: res_re expected %h actual %h", $time, w.res_re, rsp.res_re);
            if (rsp.res_im !== w.res_im)
               $display("%0t: res_im expected %h actual %h", $time, w.res_im, rsp.res_im);
            if (rsp.overflow !== w.overflow)
               $display("%0t: overflow expected %b actual %b", $time, w.overflow, rsp.overflow);
            if (rsp.div_zero !== w.div_zero)
               $display("%0t: div_zero expected %b actual %b", $time, w.div_zero, rsp.div_zero);
            if (rsp !== w) errors++;
         end
      end
   end

   // Stimulus and end of run.
   initial begin
      stim_row_type table_q[$];
      req_type      r;
      int           wait_cnt;
      table_q.push_back(row_exp(row(ACT_ADD, 0, 0, 0, 0), '{0, 0, 1'b0, 1'b0}));
      table_q.push_back(row_exp(row(ACT_ADD, MaxVal, MaxVal, MaxVal, MaxVal),
                                '{MaxVal, MaxVal, 1'b1, 1'b0}));
      table_q.push_back(row_exp(row(ACT_SUB, MinVal, 0, 1, 0), '{MinVal, 0, 1'b1, 1'b0}));
      table_q.push_back(row_exp(row(ACT_DIV, One, -One, 0, 0), '{0, 0, 1'b0, 1'b1}));
      table_q.push_back(row_exp(row(ACT_DIV, MaxVal, MinVal, 0, 0), '{0, 0, 1'b0, 1'b1}));
      table_q.push_back(row_exp(row(ACT_MUL, One, 0, One, 0), '{One, 0, 1'b0, 1'b0}));
      table_q.push_back(row(ACT_ADD, MinVal, MinVal, MinVal, MinVal));
      table_q.push_back(row(ACT_SUB, MaxVal, MinVal, MinVal, MaxVal));
      table_q.push_back(row(ACT_SUB, 5, -7, 5, -7));
      table_q.push_back(row(ACT_MUL, MinVal, MinVal, MinVal, MinVal));
      table_q.push_back(row(ACT_MUL, MaxVal, MinVal, MaxVal, MaxVal));
      table_q.push_back(row(ACT_MUL, 32'sh8000, 0, 1, 0));
      table_q.push_back(row(ACT_MUL, -32'sh8000, 0, 1, 0));
      table_q.push_back(row(ACT_MUL, 32'sh7fff, -32'sh7fff, 1, 1));
      table_q.push_back(row(ACT_DIV, One, 0, 3 * One, 0));
      table_q.push_back(row(ACT_DIV, -One, One, 3 * One, -One));
      table_q.push_back(row(ACT_DIV, MaxVal, MaxVal, 1, 0));
      table_q.push_back(row(ACT_DIV, MinVal, MaxVal, MinVal, MinVal));
      table_q.push_back(row(ACT_DIV, 1, -1, MaxVal, MinVal));
      table_q.push_back(row(ACT_DIV, 0, 0, 0, 1));
      table_q.push_back(row(ACT_DIV, One, One, One, One));

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table.
      foreach (table_q[i])
         send_item(table_q[i].r, table_q[i].typed ? table_q[i].want
                                                  : complex_result(table_q[i].r));

      // Random traffic in three idling phases.
      for (int ph = 0; ph < 3; ph++) begin
         snd_idle = (ph == 0) ? 15 : (ph == 1) ? 80 : 0;
         rcv_idle = (ph == 0) ? 80 : (ph == 1) ? 15 : 0;
         for (int n = 0; n < RandItems / 3; n++) begin
            r.action = action_type'($urandom_range(3));
            r.a_re = rand_operand();
            r.a_im = rand_operand();
            r.b_re = rand_operand();
            r.b_im = rand_operand();
            if ($urandom_range(19) == 0) begin
               r.b_re = 0;
               r.b_im = 0;
            end
            send_item(r, complex_result(r));
         end
      end
      req_valid <= 1'b0;

      wait_cnt = 0;
      while (pending_q.size() != 0 && wait_cnt < 100000) begin
         @(posedge clock);
         wait_cnt++;
      end
      repeat (60) @(posedge clock);
      if (pending_q.size() != 0) begin
         $display("%0t: %0d results never arrived", $time, pending_q.size());
         errors++;
      end
      $display("Checked %0d results over all four operations and three idling phases.", checked);
      $display("%0d results saturated, %0d zero divisors seen.", n_ovf, n_div_zero);
      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // Watchdog.
   initial begin
      #5_000_000;
      $display("FAILURE");
      $finish;
   end
endmodule
